// ===== hdl/mtg_pkg.sv =====
package mtg_pkg;

    // state geometry
    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int IDX_W        = $clog2(STATE_WORDS);

    // twist, tempering and seeding constants
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [31:0] SEED_MULT    = 32'd69069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;
    localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK   = 32'h7FFF_FFFF;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [31:0]      word_t;

    // write request into the state memory
    typedef struct packed {
        logic  en;
        idx_t  addr;
        word_t data;
    } ram_wr_t;

endpackage

// ===== hdl/mtg_state_ram.sv =====
module mtg_state_ram (
    input  logic            clk,
    input  mtg_pkg::ram_wr_t wr,
    input  mtg_pkg::idx_t   rd_addr_a,
    input  mtg_pkg::idx_t   rd_addr_b,
    output mtg_pkg::word_t  rd_data_a,
    output mtg_pkg::word_t  rd_data_b
);
    import mtg_pkg::*;

    word_t mem [STATE_WORDS];
    word_t rd_a_reg;
    word_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== hdl/mtg_twist_temper.sv =====
module mtg_twist_temper (
    input  mtg_pkg::word_t cur_word,
    input  mtg_pkg::word_t next_word,
    input  mtg_pkg::word_t far_word,
    output mtg_pkg::word_t twisted_word,
    output mtg_pkg::word_t tempered_word
);
    import mtg_pkg::*;

    word_t y;
    word_t t0;
    word_t t1;
    word_t t2;

    always_comb
    begin
        y            = (cur_word & UPPER_MASK) | (next_word & LOWER_MASK);
        twisted_word = far_word ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
        // tempering
        t0            = twisted_word ^ (twisted_word >> 11);
        t1            = t0 ^ ((t0 << 7) & TEMPER_B);
        t2            = t1 ^ ((t1 << 15) & TEMPER_C);
        tempered_word = t2 ^ (t2 >> 18);
    end

endmodule

// ===== hdl/mersenne_twister_word_generator_unit.sv =====
// an accepted draw goes from idle to the twist state, which registers its tempered word
//   when the output is free; a reseed first runs the seeding sweep and a memory read state
// no new draw is taken until the last word is registered and written back to memory
// reset: seed register returns to 4357, read index to 0 and the generator is marked unseeded;
//   the state memory is not cleared, the first draw always seeds it before use
module mersenne_twister_word_generator_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    // draw requests
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    // generated words
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           random_word,
    // seed register write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           seed_value
);
    import mtg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_CALC
    } state_t;

    localparam idx_t LAST_IDX = idx_t'(STATE_WORDS - 1);

    state_t  state_reg;
    idx_t    idx_reg;          // word being drawn, also the seeding sweep pointer
    logic    unseeded_reg;
    word_t   seed_reg;         // configured seed
    word_t   x_reg;            // running seed product
    word_t   cur_reg;          // copy of the state word at idx_reg
    logic    out_valid_reg;
    word_t   word_reg;

    word_t   x_next;
    idx_t    idx_next;
    idx_t    next_addr;
    idx_t    far_addr;
    logic [IDX_W:0] far_sum;
    word_t   next_data;
    word_t   far_data;
    word_t   twisted;
    word_t   tempered;
    ram_wr_t ram_wr;
    logic    out_free;
    logic    in_accept;
    logic    calc_fire;

    // the word after idx and the word SHIFT_OFFSET ahead, both modulo the state size
    always_comb
    begin
        idx_next  = (idx_reg == LAST_IDX) ? '0 : idx_reg + idx_t'(1);
        next_addr = idx_next;
        far_sum   = {1'b0, idx_reg} + (IDX_W + 1)'(SHIFT_OFFSET);
        if (far_sum >= (IDX_W + 1)'(STATE_WORDS))
        begin
            far_addr = idx_t'(far_sum - (IDX_W + 1)'(STATE_WORDS));
        end
        else
        begin
            far_addr = idx_t'(far_sum);
        end
    end

    // seeding recurrence, low 32 bits of the product
    assign x_next = 32'(x_reg * SEED_MULT);

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign calc_fire = (state_reg == ST_CALC) && out_free;
    assign cfg_ready = 1'b1;

    // memory writes: the seeding sweep, or the twisted word written back in place
    always_comb
    begin
        ram_wr.en   = 1'b0;
        ram_wr.addr = idx_reg;
        ram_wr.data = twisted;
        if (state_reg == ST_SEED)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.data = x_reg;
        end
        else if (calc_fire)
        begin
            ram_wr.en = 1'b1;
        end
    end

    // reads follow idx_reg every cycle, so data is ready the cycle after a draw is taken
    mtg_state_ram u_ram (
        .clk       (clk),
        .wr        (ram_wr),
        .rd_addr_a (next_addr),
        .rd_addr_b (far_addr),
        .rd_data_a (next_data),
        .rd_data_b (far_data)
    );

    // twisting in place on the fly: words below idx already hold the new generation,
    // which is exactly what the whole-state regeneration would read
    mtg_twist_temper u_twist (
        .cur_word      (cur_reg),
        .next_word     (next_data),
        .far_word      (far_data),
        .twisted_word  (twisted),
        .tempered_word (tempered)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            unseeded_reg  <= 1'b1;
            seed_reg      <= DEFAULT_SEED;
            x_reg         <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            word_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= seed_value;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (restart || unseeded_reg)
                        begin
                            // reseed, restart counts from word 0
                            x_reg        <= (restart ? seed_reg : DEFAULT_SEED) | 32'd1;
                            unseeded_reg <= 1'b0;
                            idx_reg      <= '0;
                            state_reg    <= ST_SEED;
                        end
                        else
                        begin
                            state_reg <= ST_CALC;
                        end
                    end
                end
                ST_SEED:
                begin
                    if (idx_reg == '0)
                    begin
                        cur_reg <= x_reg;
                    end
                    x_reg <= x_next;
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + idx_t'(1);
                    end
                end
                ST_READ:
                begin
                    // wait state for the memory reads at word 0
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        word_reg      <= tempered;
                        cur_reg       <= next_data;
                        idx_reg       <= idx_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

endmodule

// ===== hdl/mtg_checker.sv =====
module mtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] random_word
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // draws taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_busy_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("generator took a draw and was not busy next cycle");

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_word))
        else $error("stalled word dropped or changed");

    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("word shown with no draw outstanding");

    a_two_in_flight_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> in_stall)
        else $error("third draw could be taken while two are outstanding");

endmodule

bind mersenne_twister_word_generator_unit mtg_checker u_mtg_checker (.*);

// ===== tb/tb_mersenne_twister_word_generator_unit.sv =====
module tb_mersenne_twister_word_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 4;
    localparam int TAIL        = 20;

    // dut signals, all inputs known from time zero
    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  in_valid    = 1'b0;
    logic  in_stall;
    logic  restart     = 1'b0;
    logic  out_valid;
    logic  out_stall   = 1'b0;
    word_t random_word;
    logic  cfg_valid   = 1'b0;
    logic  cfg_ready;
    word_t seed_value  = DEFAULT_SEED;

    // draw requests waiting to be offered, words the generator still owes
    bit    draw_queue[$];
    word_t expected_words[$];

    // knobs that the sequence block sets between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_arm      = 1'b0;

    // long output hold-off, owned by its own process
    int unsigned hold_left;
    bit          hold_done;

    int unsigned words_checked = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    // private copy of the generator: state words, read position, seed register
    word_t       gen_words [STATE_WORDS];
    int unsigned gen_pos      = 0;
    bit          gen_unseeded = 1'b1;
    word_t       seed_copy    = DEFAULT_SEED;

    mersenne_twister_word_generator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .seed_value  (seed_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // fill all state words from a seed with the linear congruential sweep
    function automatic void seed_state(input word_t s);
        word_t x;
        x = s | 32'h1;
        gen_words[0] = x;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            x = x * SEED_MULT;
            gen_words[i] = x;
        end
        // marks the state as used up, so the same draw twists first
        gen_pos      = STATE_WORDS;
        gen_unseeded = 1'b0;
    endfunction

    // the tempered word that one accepted draw must produce
    function automatic word_t next_word(input bit reseed);
        word_t y;
        word_t nxt;
        word_t far;
        if (reseed)
            seed_state(seed_copy);
        else if (gen_unseeded)
            seed_state(DEFAULT_SEED);   // draw before any seeding ignores the register
        if (gen_pos >= STATE_WORDS)
        begin
            // in-place twist, later words already see the updated earlier ones
            for (int i = 0; i < STATE_WORDS; i++)
            begin
                nxt = gen_words[(i + 1) % STATE_WORDS];
                far = gen_words[(i + SHIFT_OFFSET) % STATE_WORDS];
                y   = (gen_words[i] & UPPER_MASK) | (nxt & LOWER_MASK);
                gen_words[i] = far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
            end
            gen_pos = 0;
        end
        y = gen_words[gen_pos];
        gen_pos++;
        // tempering
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic void note_error(input string what, input word_t want, input word_t got);
        error_count++;
        if (error_count <= 10)
            $display("error at cycle %0d: %s, expected %08h got %08h",
                     cycle_count, what, want, got);
    endfunction

    // draw driver: offers the next queued request, holds it while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // request taken at this edge, predict its word now
            if (in_valid && !in_stall)
                expected_words.push_back(next_word(restart));
            // free to change the offer only when nothing is stuck on the port
            if (!in_valid || !in_stall)
            begin
                if (draw_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    restart  <= draw_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started once on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // word monitor: checks every taken word against the oldest prediction
    always @(posedge clk)
    begin
        word_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    note_error("word with no draw pending", 32'h0, random_word);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (random_word !== want)
                        note_error("random_word mismatch", want, random_word);
                end
                words_checked++;
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sender stays quiet until every owed word has come back
    task automatic wait_drained();
        while (draw_queue.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // seed register write, only issued while the generator is idle
    task automatic write_seed(input word_t v);
        @(posedge clk);
        cfg_valid  <= 1'b1;
        seed_value <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_copy = v;
    endtask

    // queue a fixed restart pattern, leftmost bit goes first
    task automatic load_pattern(input bit [15:0] pattern, input int n);
        for (int i = n - 1; i >= 0; i--)
            draw_queue.push_back(pattern[i]);
    endtask

    // queue random draws, a restart roughly one in one_in, never when one_in is zero
    task automatic load_random(input int n, input int unsigned one_in);
        for (int i = 0; i < n; i++)
            draw_queue.push_back(one_in != 0 && $urandom_range(one_in - 1) == 0);
    endtask

    // test sequence
    initial
    begin
        word_t first_seed;
        int unsigned mark;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, sender rarely idle and receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 83;

        // seed register set before the first draw must not matter for plain draws
        first_seed = $urandom;
        if (first_seed == DEFAULT_SEED)
            first_seed = ~first_seed;
        write_seed(first_seed);
        load_pattern(16'b0000100, 7);   // unseeded draws, then restart from the register
        wait_drained();

        // zero seed is forced odd; back-to-back restarts
        write_seed(32'h0);
        load_pattern(16'b10110, 5);
        wait_drained();

        write_seed(32'hFFFF_FFFF);
        load_pattern(16'b1000, 4);
        wait_drained();

        write_seed(DEFAULT_SEED);
        load_pattern(16'b100, 3);
        wait_drained();

        // random phase, same idling as above
        write_seed($urandom);
        load_random(530, 150);
        wait_drained();

        // random phase, sender mostly idle and receiver rarely stalled
        send_idle_pct = 83;
        recv_idle_pct = 7;
        write_seed($urandom);
        load_random(530, 150);
        wait_drained();

        // no idling: a long restart-free run crosses the regeneration point,
        // then frequent restarts; the long hold-off lands in the middle
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed($urandom);
        load_random(640, 0);
        load_random(20, 4);
        mark = words_checked + 100;
        while (words_checked < mark)
            @(negedge clk);
        hold_arm = 1'b1;
        wait_drained();

        repeat (TAIL) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
